### hw/rtl/spg_pkg.sv
// spg_pkg: shared widths, request and register codes, reset values and
// controller/datapath handshake structs for the servo pulse generator
// no dependencies
package spg_pkg;

    localparam int POS_W    = 16;
    localparam int FRAME_W  = 20;
    localparam int KHZ_W    = 16;
    localparam int DIV_W    = 16;
    localparam int TO_W     = 8;
    localparam int REQ_W    = 2;
    localparam int NB_W     = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 20;
    localparam int FIELD_CH = 4;

    // (position + trim) is clamped to non-negative and below 2^17 when it reaches the scaler
    localparam int OPND_W   = 17;
    localparam int PROD_W   = OPND_W + KHZ_W;
    localparam int STEP_W   = $clog2(PROD_W + 1);

    localparam logic [REQ_W-1:0] REQ_TICK    = 2'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CAPTURE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CLK_KHZ     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_DIV   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd3;

    localparam logic [FRAME_W-1:0] FRAME_TICKS_RST = 20'd75000;
    localparam logic [KHZ_W-1:0]   CLK_KHZ_RST     = 16'd20000;
    localparam logic [DIV_W-1:0]   SCALE_DIV_RST   = 16'd7800;
    localparam logic [TO_W-1:0]    TIMEOUT_RST     = 8'd40;

    localparam logic [POS_W-1:0]   CENTER_US = 16'd1500;
    localparam logic [NB_W-1:0]    MAX_BYTES = 4'd8;
    localparam logic [POS_W-1:0]   LEN_MAX   = 16'hffff;

    typedef struct packed {
        logic do_tick;
        logic do_write;
        logic capture;
        logic scale_start;
        logic len_store;
    } ctrl_cmd_t;

    typedef struct packed {
        logic             item_fire;
        logic [REQ_W-1:0] req;
        logic             cfg_fire;
        logic             scale_done;
    } ctrl_sts_t;

endpackage

### hw/rtl/spg_scaler.sv
// spg_scaler: one multiply then a restoring divider, one quotient bit a cycle,
// saturating the quotient to 16 bits; uses spg_pkg
module spg_scaler
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [spg_pkg::OPND_W-1:0] opnd,
    input  logic [spg_pkg::KHZ_W-1:0]  khz,
    input  logic [spg_pkg::DIV_W-1:0]  divisor,
    output logic                       done,
    output logic [spg_pkg::POS_W-1:0]  quot
);

    logic [spg_pkg::PROD_W-1:0] acc_reg;
    logic [spg_pkg::DIV_W-1:0]  rem_reg;
    logic [spg_pkg::DIV_W-1:0]  div_reg;
    logic [spg_pkg::STEP_W-1:0] step_reg;
    logic                       run_reg;
    logic                       done_reg;

    logic [spg_pkg::DIV_W:0]    shifted;
    logic                       fits;
    logic [spg_pkg::DIV_W:0]    diff;

    // acc shifts the dividend out at the top and the quotient in at the bottom
    assign shifted = {rem_reg, acc_reg[spg_pkg::PROD_W-1]};
    assign fits    = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            step_reg <= spg_pkg::STEP_W'(spg_pkg::PROD_W);
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (run_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == spg_pkg::STEP_W'(1))
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= spg_pkg::PROD_W'(opnd) * spg_pkg::PROD_W'(khz);
            rem_reg <= '0;
            div_reg <= (divisor == '0) ? spg_pkg::DIV_W'(1) : divisor;
        end
        else if (run_reg)
        begin
            acc_reg <= {acc_reg[spg_pkg::PROD_W-2:0], fits};
            rem_reg <= fits ? diff[spg_pkg::DIV_W-1:0] : shifted[spg_pkg::DIV_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = (|acc_reg[spg_pkg::PROD_W-1:spg_pkg::POS_W]) ? spg_pkg::LEN_MAX
                                                                : acc_reg[spg_pkg::POS_W-1:0];

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(run_reg))
        else $error("scaler done without a running division");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> !done_reg)
        else $error("scaler done while still dividing");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_reg |-> (step_reg != '0))
        else $error("scaler step count ran out while running");

endmodule

### hw/rtl/spg_datapath.sv
// spg_datapath: configuration registers, positions, trims, scaled lengths,
// frame counter and pin levels; instantiates spg_scaler, uses spg_pkg
module spg_datapath #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  spg_pkg::ctrl_cmd_t            cmd,
    input  logic [CH_W-1:0]               ch_sel,
    input  logic                          cfg_we,
    input  logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spg_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic [spg_pkg::NB_W-1:0]      write_bytes,
    input  logic [spg_pkg::POS_W-1:0]     pos_zero,
    input  logic [spg_pkg::POS_W-1:0]     pos_one,
    input  logic [spg_pkg::POS_W-1:0]     pos_two,
    input  logic [spg_pkg::POS_W-1:0]     pos_three,
    output logic [CHANNELS-1:0]           pin_levels,
    output logic                          active,
    output logic                          scale_done
);

    logic [spg_pkg::FRAME_W-1:0] frame_ticks_reg;
    logic [spg_pkg::KHZ_W-1:0]   clk_khz_reg;
    logic [spg_pkg::DIV_W-1:0]   scale_div_reg;
    logic [spg_pkg::TO_W-1:0]    timeout_reg;

    logic [spg_pkg::POS_W-1:0]   position_reg [CHANNELS];
    logic [spg_pkg::POS_W-1:0]   trim_reg     [CHANNELS];
    logic [spg_pkg::POS_W-1:0]   plen_reg     [CHANNELS];
    logic [spg_pkg::POS_W-1:0]   cand_reg     [CHANNELS];
    logic [spg_pkg::TO_W-1:0]    frames_left_reg;
    logic [spg_pkg::FRAME_W-1:0] frame_count_reg;
    logic [CHANNELS-1:0]         pin_reg;
    logic                        active_reg;

    logic [spg_pkg::POS_W-1:0]   position_next [CHANNELS];
    logic [spg_pkg::POS_W-1:0]   trim_next     [CHANNELS];
    logic [spg_pkg::POS_W-1:0]   pos_in        [CHANNELS];
    logic [CHANNELS-1:0]         pin_tick;
    logic [spg_pkg::NB_W-1:0]    nbytes;
    logic                        frame_start;
    logic                        drive;
    logic [spg_pkg::FRAME_W:0]   count_inc;
    logic [spg_pkg::FRAME_W-1:0] count_next;

    logic [spg_pkg::POS_W-1:0]   pos_sel;
    logic [spg_pkg::POS_W-1:0]   trim_sel;
    logic signed [spg_pkg::OPND_W:0] sum;
    logic [spg_pkg::OPND_W-1:0]  opnd;
    logic [spg_pkg::POS_W-1:0]   quot;

    // only the first four channels have a position field
    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_pos_in
        if (g == 0)
        begin : g_f0
            assign pos_in[g] = pos_zero;
        end
        else if (g == 1)
        begin : g_f1
            assign pos_in[g] = pos_one;
        end
        else if (g == 2)
        begin : g_f2
            assign pos_in[g] = pos_two;
        end
        else if (g == 3)
        begin : g_f3
            assign pos_in[g] = pos_three;
        end
        else
        begin : g_fx
            assign pos_in[g] = spg_pkg::CENTER_US;
        end
    end

    // byte-wise position update, then optional trim capture
    always_comb
    begin
        logic [spg_pkg::POS_W-1:0] merged;
        logic lo_we;
        logic hi_we;
        if (cmd.capture || (write_bytes > spg_pkg::MAX_BYTES))
            nbytes = spg_pkg::MAX_BYTES;
        else
            nbytes = write_bytes;
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            lo_we  = (ch < spg_pkg::FIELD_CH) && (nbytes > spg_pkg::NB_W'(2 * ch));
            hi_we  = (ch < spg_pkg::FIELD_CH) && (nbytes > spg_pkg::NB_W'(2 * ch + 1));
            merged = {hi_we ? pos_in[ch][15:8] : position_reg[ch][15:8],
                      lo_we ? pos_in[ch][7:0]  : position_reg[ch][7:0]};
            if (cmd.capture)
            begin
                position_next[ch] = spg_pkg::CENTER_US;
                trim_next[ch]     = merged - spg_pkg::CENTER_US;
            end
            else
            begin
                position_next[ch] = merged;
                trim_next[ch]     = trim_reg[ch];
            end
        end
    end

    // one timer tick: frame start, then each pin against its own length
    always_comb
    begin
        logic [spg_pkg::POS_W-1:0] len_eff;
        logic                      pin_mid;
        frame_start = (frame_count_reg == '0);
        drive       = frame_start && (frames_left_reg != '0);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            len_eff      = drive ? cand_reg[ch] : plen_reg[ch];
            pin_mid      = frame_start ? drive : pin_reg[ch];
            pin_tick[ch] = pin_mid &&
                           ({{(spg_pkg::FRAME_W-spg_pkg::POS_W){1'b0}}, len_eff}
                            > frame_count_reg);
        end
        count_inc = {1'b0, frame_count_reg} + 1'b1;
        if (count_inc >= {1'b0, frame_ticks_reg})
            count_next = '0;
        else
            count_next = count_inc[spg_pkg::FRAME_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_ticks_reg <= spg_pkg::FRAME_TICKS_RST;
            clk_khz_reg     <= spg_pkg::CLK_KHZ_RST;
            scale_div_reg   <= spg_pkg::SCALE_DIV_RST;
            timeout_reg     <= spg_pkg::TIMEOUT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spg_pkg::CFG_FRAME_TICKS: frame_ticks_reg <= cfg_data;
                spg_pkg::CFG_CLK_KHZ:     clk_khz_reg     <= cfg_data[spg_pkg::KHZ_W-1:0];
                spg_pkg::CFG_SCALE_DIV:   scale_div_reg   <= cfg_data[spg_pkg::DIV_W-1:0];
                spg_pkg::CFG_TIMEOUT:     timeout_reg     <= cfg_data[spg_pkg::TO_W-1:0];
                default:                  timeout_reg     <= timeout_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                position_reg[ch] <= spg_pkg::CENTER_US;
                trim_reg[ch]     <= '0;
                plen_reg[ch]     <= '0;
            end
            frames_left_reg <= spg_pkg::TIMEOUT_RST;
            frame_count_reg <= '0;
            pin_reg         <= '0;
            active_reg      <= 1'b0;
        end
        else if (cmd.do_write)
        begin
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                position_reg[ch] <= position_next[ch];
                trim_reg[ch]     <= trim_next[ch];
            end
            frames_left_reg <= timeout_reg;
        end
        else if (cmd.do_tick)
        begin
            if (drive)
            begin
                for (int ch = 0; ch < CHANNELS; ch++)
                    plen_reg[ch] <= cand_reg[ch];
                frames_left_reg <= frames_left_reg - 1'b1;
            end
            if (frame_start)
                active_reg <= drive;
            pin_reg         <= pin_tick;
            frame_count_reg <= count_next;
        end
    end

    // precomputed lengths, refreshed one channel at a time by the controller
    always_ff @(posedge clk)
    begin
        if (cmd.len_store)
            cand_reg[ch_sel] <= quot;
    end

    assign pos_sel  = position_reg[ch_sel];
    assign trim_sel = trim_reg[ch_sel];
    assign sum      = $signed({2'b00, pos_sel}) + $signed({{2{trim_sel[15]}}, trim_sel});
    assign opnd     = (sum > 0) ? sum[spg_pkg::OPND_W-1:0] : '0;

    spg_scaler u_scaler
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.scale_start),
        .opnd    (opnd),
        .khz     (clk_khz_reg),
        .divisor (scale_div_reg),
        .done    (scale_done),
        .quot    (quot)
    );

    assign pin_levels = pin_reg;
    assign active     = active_reg;

endmodule

### hw/rtl/spg_ctrl.sv
// spg_ctrl: decodes accepted words into datapath commands and sequences the
// per-channel length recompute; uses spg_pkg
module spg_ctrl #(
    parameter int CHANNELS = 4,
    parameter int CH_W     = 2
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  spg_pkg::ctrl_sts_t sts,
    output spg_pkg::ctrl_cmd_t cmd,
    output logic [CH_W-1:0]    ch_sel,
    output logic               busy
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_START = 2'd1;
    localparam logic [1:0] S_WAIT  = 2'd2;

    logic [1:0]      state_reg;
    logic [1:0]      state_next;
    logic [CH_W-1:0] ch_reg;
    logic [CH_W-1:0] ch_next;
    logic            last_ch;

    assign last_ch = (ch_reg == CH_W'(CHANNELS - 1));

    always_comb
    begin
        state_next = state_reg;
        ch_next    = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (sts.cfg_fire || (sts.item_fire &&
                    (sts.req == spg_pkg::REQ_WRITE || sts.req == spg_pkg::REQ_CAPTURE)))
                begin
                    state_next = S_START;
                    ch_next    = '0;
                end
            end
            S_START:
            begin
                state_next = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.scale_done)
                begin
                    if (last_ch)
                        state_next = S_IDLE;
                    else
                    begin
                        state_next = S_START;
                        ch_next    = ch_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // reset leaves a recompute pending so the lengths match the reset settings
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_START;
            ch_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
        end
    end

    always_comb
    begin
        cmd.do_tick     = sts.item_fire && (sts.req == spg_pkg::REQ_TICK);
        cmd.do_write    = sts.item_fire &&
                          (sts.req == spg_pkg::REQ_WRITE || sts.req == spg_pkg::REQ_CAPTURE);
        cmd.capture     = sts.item_fire && (sts.req == spg_pkg::REQ_CAPTURE);
        cmd.scale_start = (state_reg == S_START);
        cmd.len_store   = (state_reg == S_WAIT) && sts.scale_done;
    end

    assign ch_sel = ch_reg;
    assign busy   = (state_reg != S_IDLE);

    a_no_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !sts.item_fire && !sts.cfg_fire)
        else $error("word accepted during recompute");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.len_store |-> (ch_reg <= CH_W'(CHANNELS - 1)))
        else $error("length stored to a channel that does not exist");

    a_start_then_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale_start |=> (state_reg == S_WAIT) && !cmd.scale_start)
        else $error("scaler started twice for one channel");

endmodule

### hw/rtl/four_channel_servo_pulse_gen_core.sv
// four_channel_servo_pulse_gen_core: ticks go back to back while out_ready is high;
// the result word is valid the cycle after its input word is accepted.
// a position write or a config write starts a recompute of all scaled lengths:
// one multiply, 33 divider steps and one store for each channel in turn, with
// input and config ready low meanwhile.
// reset (async, active low) restores defaults and runs the same recompute.
module four_channel_servo_pulse_gen_core #(
    parameter int CHANNELS = 4
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [spg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spg_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [spg_pkg::REQ_W-1:0]     req_type,
    input  logic [spg_pkg::NB_W-1:0]      write_bytes,
    input  logic [spg_pkg::POS_W-1:0]     pos_zero,
    input  logic [spg_pkg::POS_W-1:0]     pos_one,
    input  logic [spg_pkg::POS_W-1:0]     pos_two,
    input  logic [spg_pkg::POS_W-1:0]     pos_three,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [3:0]                    servo_levels,
    output logic                          frame_active
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    spg_pkg::ctrl_cmd_t  cmd;
    spg_pkg::ctrl_sts_t  sts;
    logic [CH_W-1:0]     ch_sel;
    logic                busy;
    logic                scale_done;
    logic                in_fire;
    logic                cfg_fire;
    logic                out_valid_reg;
    logic [CHANNELS-1:0] pin_levels;
    logic                active;

    assign in_ready  = !busy && (!out_valid_reg || out_ready);
    assign cfg_ready = !busy;
    assign in_fire   = in_valid && in_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        sts.item_fire  = in_fire;
        sts.req        = req_type;
        sts.cfg_fire   = cfg_fire;
        sts.scale_done = scale_done;
    end

    spg_ctrl #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .sts    (sts),
        .cmd    (cmd),
        .ch_sel (ch_sel),
        .busy   (busy)
    );

    spg_datapath #(
        .CHANNELS (CHANNELS),
        .CH_W     (CH_W)
    ) u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .ch_sel      (ch_sel),
        .cfg_we      (cfg_fire),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .write_bytes (write_bytes),
        .pos_zero    (pos_zero),
        .pos_one     (pos_one),
        .pos_two     (pos_two),
        .pos_three   (pos_three),
        .pin_levels  (pin_levels),
        .active      (active),
        .scale_done  (scale_done)
    );

    // a new word is taken only when the output slot is free or draining,
    // so the pin state itself is the result payload
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_comb
    begin
        servo_levels = '0;
        for (int i = 0; i < spg_pkg::FIELD_CH; i++)
        begin
            if (i < CHANNELS)
                servo_levels[i] = pin_levels[i];
        end
    end

    assign out_valid    = out_valid_reg;
    assign frame_active = active;

    a_write_recomputes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && (req_type == spg_pkg::REQ_WRITE || req_type == spg_pkg::REQ_CAPTURE))
        |=> busy)
        else $error("position write did not start a recompute");

    a_cfg_recomputes: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_fire |=> busy)
        else $error("config write did not start a recompute");

    a_pins_hold_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(pin_levels) && $stable(active))
        else $error("pins moved during recompute");

    a_idle_frame_low: assert property (@(posedge clk) disable iff (!rst_n)
        !active |-> (pin_levels == '0))
        else $error("pin high outside a driving frame");

endmodule

### tb/four_channel_servo_pulse_gen_core_tb.sv
// four_channel_servo_pulse_gen_core_tb: self-checking bench for the servo pulse core,
// a directed script then fixed register phases with randomized traffic, every result
// word checked against a scripted or predicted value; needs spg_pkg and the core only
`timescale 1ns / 100ps

module four_channel_servo_pulse_gen_core_tb;

    import spg_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_COUNT = 7;

    typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic [NB_W-1:0]  nbytes;
        logic [POS_W-1:0] pos0;
        logic [POS_W-1:0] pos1;
        logic [POS_W-1:0] pos2;
        logic [POS_W-1:0] pos3;
    } servo_req_t;

    typedef struct packed {
        logic [3:0] levels;
        logic       active;
    } pin_word_t;

    typedef struct packed {
        logic                 is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_DAT_W-1:0] reg_val;
        servo_req_t           word;
        logic                 typed;
        pin_word_t            want;
    } script_row_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame_ticks;
        logic [KHZ_W-1:0]   khz;
        logic [DIV_W-1:0]   divisor;
        logic [TO_W-1:0]    timeout;
        idle_mode_t         mode;
        logic [11:0]        count;
    } phase_t;

    localparam phase_t PHASES [PHASE_COUNT] = '{
        '{20'd40,      16'd1,     16'd100,   8'd3,   IDLE_NONE, 12'd260},
        '{20'd1,       16'd65535, 16'd1,     8'd255, IDLE_TX,   12'd180},
        '{20'd100,     16'd3,     16'd200,   8'd1,   IDLE_RX,   12'd260},
        '{20'hfffff,   16'd20000, 16'd7800,  8'd40,  IDLE_BOTH, 12'd80},
        '{20'd25,      16'd7,     16'd400,   8'd255, IDLE_NONE, 12'd260},
        '{20'd60,      16'd2,     16'd150,   8'd4,   IDLE_BOTH, 12'd200},
        '{20'd30,      16'd1,     16'd65535, 8'd2,   IDLE_TX,   12'd210}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [REQ_W-1:0]     req_type;
    logic [NB_W-1:0]      write_bytes;
    logic [POS_W-1:0]     pos_zero;
    logic [POS_W-1:0]     pos_one;
    logic [POS_W-1:0]     pos_two;
    logic [POS_W-1:0]     pos_three;
    logic                 out_valid;
    logic                 out_ready;
    logic [3:0]           servo_levels;
    logic                 frame_active;

    // shadow copy of the block state and registers
    logic [POS_W-1:0]   shadow_pos [FIELD_CH];
    logic [POS_W-1:0]   shadow_trim [FIELD_CH];
    logic [POS_W-1:0]   shadow_len [FIELD_CH];
    logic [TO_W-1:0]    shadow_frames_left;
    logic [FRAME_W-1:0] shadow_frame_cnt;
    logic [3:0]         shadow_pins;
    logic               shadow_active;
    logic [FRAME_W-1:0] shadow_frame_ticks;
    logic [KHZ_W-1:0]   shadow_khz;
    logic [DIV_W-1:0]   shadow_div;
    logic [TO_W-1:0]    shadow_timeout;

    pin_word_t   pin_words_due [$];
    script_row_t script [$];

    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int position_writes = 0;
    int driven_frames = 0;
    int reg_writes = 0;
    int tx_gap_pct = 0;
    int rx_stall_pct = 0;
    int hold_requests = 0;

    four_channel_servo_pulse_gen_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .write_bytes  (write_bytes),
        .pos_zero     (pos_zero),
        .pos_one      (pos_one),
        .pos_two      (pos_two),
        .pos_three    (pos_three),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .servo_levels (servo_levels),
        .frame_active (frame_active)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic logic [POS_W-1:0] scaled_len(int ch);
        int     sum;
        longint q;
        longint dv;
        sum = int'(shadow_pos[ch]) + int'($signed(shadow_trim[ch]));
        dv = (shadow_div == '0) ? 64'd1 : longint'(shadow_div);
        if (sum <= 0)
            return '0;
        q = longint'(sum) * longint'(shadow_khz) / dv;
        return (q > 65535) ? LEN_MAX : q[POS_W-1:0];
    endfunction

    function automatic pin_word_t predict_pins(servo_req_t w);
        logic [POS_W-1:0] src [FIELD_CH];
        logic [FRAME_W:0] nxt;
        int               nb;
        pin_word_t        r;
        src = '{w.pos0, w.pos1, w.pos2, w.pos3};
        case (w.req)
            REQ_TICK:
            begin
                if (shadow_frame_cnt == '0)
                begin
                    shadow_pins = '0;
                    shadow_active = 1'b0;
                    if (shadow_frames_left != '0)
                    begin
                        shadow_frames_left = shadow_frames_left - 1'b1;
                        for (int ch = 0; ch < FIELD_CH; ch++)
                            shadow_len[ch] = scaled_len(ch);
                        shadow_pins = '1;
                        shadow_active = 1'b1;
                        driven_frames++;
                    end
                end
                // a zero length rises and falls on the same tick
                for (int ch = 0; ch < FIELD_CH; ch++)
                    if (shadow_pins[ch] && shadow_frame_cnt >= shadow_len[ch])
                        shadow_pins[ch] = 1'b0;
                nxt = shadow_frame_cnt + 1'b1;
                shadow_frame_cnt = (nxt >= shadow_frame_ticks) ? '0 : nxt[FRAME_W-1:0];
            end
            REQ_WRITE, REQ_CAPTURE:
            begin
                nb = (w.req == REQ_CAPTURE || w.nbytes > MAX_BYTES) ? int'(MAX_BYTES)
                                                                    : int'(w.nbytes);
                // little-endian: even byte is the low half of a channel
                for (int k = 0; k < nb; k++)
                    shadow_pos[k / 2][(k % 2) * 8 +: 8] = src[k / 2][(k % 2) * 8 +: 8];
                shadow_frames_left = shadow_timeout;
                if (w.req == REQ_CAPTURE)
                begin
                    for (int ch = 0; ch < FIELD_CH; ch++)
                    begin
                        shadow_trim[ch] = shadow_pos[ch] - CENTER_US;
                        shadow_pos[ch] = CENTER_US;
                    end
                end
                position_writes++;
            end
            default:
            begin
            end
        endcase
        r.levels = shadow_pins;
        r.active = shadow_active;
        return r;
    endfunction

    function automatic script_row_t item_row(logic [REQ_W-1:0] req, logic [NB_W-1:0] nb,
                                             logic [POS_W-1:0] a, logic [POS_W-1:0] b,
                                             logic [POS_W-1:0] c, logic [POS_W-1:0] d);
        script_row_t r;
        r = '0;
        r.word = '{req, nb, a, b, c, d};
        return r;
    endfunction

    function automatic script_row_t reg_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DAT_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_reg = 1'b1;
        r.reg_idx = idx;
        r.reg_val = val;
        return r;
    endfunction

    function automatic script_row_t checked_row(script_row_t r, logic [3:0] lv, logic act);
        r.typed = 1'b1;
        r.want = '{lv, act};
        return r;
    endfunction

    function automatic logic [POS_W-1:0] random_position();
        int style;
        style = $urandom_range(0, 9);
        if (style < 4)
            return 16'($urandom_range(0, 64));
        if (style < 7)
            return 16'(1400 + $urandom_range(0, 200));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic servo_req_t random_word();
        servo_req_t w;
        int         pick;
        pick = $urandom_range(0, 99);
        if (pick < 78)
            w.req = REQ_TICK;
        else if (pick < 90)
            w.req = REQ_WRITE;
        else if (pick < 96)
            w.req = REQ_CAPTURE;
        else
            w.req = REQ_UNUSED;
        w.nbytes = 4'($urandom_range(0, 15));
        w.pos0 = random_position();
        w.pos1 = random_position();
        w.pos2 = random_position();
        w.pos3 = random_position();
        return w;
    endfunction

    task automatic push_word(input servo_req_t w, input logic typed, input pin_word_t want);
        pin_word_t guess;
        while ($urandom_range(0, 99) < tx_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= w.req;
        write_bytes <= w.nbytes;
        pos_zero    <= w.pos0;
        pos_one     <= w.pos1;
        pos_two     <= w.pos2;
        pos_three   <= w.pos3;
        do @(posedge clk); while (!in_ready);
        guess = predict_pins(w);
        pin_words_due.push_back(typed ? want : guess);
        words_sent++;
    endtask

    // registers only change with no word in flight
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        in_valid <= 1'b0;
        do @(posedge clk); while (pin_words_due.size() != 0);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_FRAME_TICKS: shadow_frame_ticks = val[FRAME_W-1:0];
            CFG_CLK_KHZ:     shadow_khz = val[KHZ_W-1:0];
            CFG_SCALE_DIV:   shadow_div = val[DIV_W-1:0];
            default:         shadow_timeout = val[TO_W-1:0];
        endcase
        reg_writes++;
    endtask

    // receiver: random stalls, plus a long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != 0)
            begin
                hold_requests--;
                out_ready <= 1'b0;
                for (int i = 0; i < HOLD_CYCLES; i++)
                    @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        pin_word_t got;
        pin_word_t due;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{servo_levels, frame_active};
            if (pin_words_due.size() == 0)
            begin
                $display("%0t: result with nothing due: servo_levels %h frame_active %b",
                         $time, got.levels, got.active);
                mismatches++;
            end
            else
            begin
                due = pin_words_due.pop_front();
                words_checked++;
                if (got.levels !== due.levels)
                begin
                    $display("%0t: servo_levels expected %h, actual %h",
                             $time, due.levels, got.levels);
                    mismatches++;
                end
                if (got.active !== due.active)
                begin
                    $display("%0t: frame_active expected %b, actual %b",
                             $time, due.active, got.active);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
                || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        int half;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        req_type    = REQ_TICK;
        write_bytes = '0;
        pos_zero    = '0;
        pos_one     = '0;
        pos_two     = '0;
        pos_three   = '0;
        for (int ch = 0; ch < FIELD_CH; ch++)
        begin
            shadow_pos[ch]  = CENTER_US;
            shadow_trim[ch] = '0;
            shadow_len[ch]  = '0;
        end
        shadow_frames_left = TIMEOUT_RST;
        shadow_frame_cnt   = '0;
        shadow_pins        = '0;
        shadow_active      = 1'b0;
        shadow_frame_ticks = FRAME_TICKS_RST;
        shadow_khz         = CLK_KHZ_RST;
        shadow_div         = SCALE_DIV_RST;
        shadow_timeout     = TIMEOUT_RST;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        script = '{
            checked_row(item_row(REQ_UNUSED, 4'd15, 16'hffff, 16'hffff, 16'hffff, 16'hffff),
                        4'h0, 1'b0),
            checked_row(item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                        4'hf, 1'b1),
            item_row(REQ_WRITE, 4'd15, 16'h0000, 16'hffff, 16'h0000, 16'hffff),
            item_row(REQ_WRITE, 4'd0, 16'h5a5a, 16'ha5a5, 16'h0f0f, 16'hf0f0),
            item_row(REQ_WRITE, 4'd3, 16'h1234, 16'habcd, 16'h8001, 16'h7ffe),
            item_row(REQ_CAPTURE, 4'd0, 16'd1500, 16'd0, 16'd65535, 16'd1600),
            item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
            // zero frame length and zero divisor
            reg_row(CFG_FRAME_TICKS, 20'd0),
            reg_row(CFG_CLK_KHZ, 20'd1),
            reg_row(CFG_SCALE_DIV, 20'd0),
            reg_row(CFG_TIMEOUT, 20'd1),
            item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
            item_row(REQ_WRITE, 4'd8, 16'd0, 16'd1500, 16'd65535, 16'd1),
            item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
            // timeout spent
            checked_row(item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                        4'h0, 1'b0),
            checked_row(item_row(REQ_CAPTURE, 4'd15, 16'd1500, 16'd1500, 16'd1500, 16'd1500),
                        4'h0, 1'b0),
            reg_row(CFG_FRAME_TICKS, 20'hfffff),
            reg_row(CFG_CLK_KHZ, 20'd65535),
            reg_row(CFG_SCALE_DIV, 20'd1),
            reg_row(CFG_TIMEOUT, 20'd255),
            // clamped length
            checked_row(item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
                        4'hf, 1'b1),
            item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000),
            // short frame: staggered falls, one pulse outlasting the frame
            reg_row(CFG_FRAME_TICKS, 20'd4),
            reg_row(CFG_CLK_KHZ, 20'd1),
            reg_row(CFG_SCALE_DIV, 20'd1),
            reg_row(CFG_TIMEOUT, 20'd2),
            item_row(REQ_WRITE, 4'd8, 16'd1, 16'd2, 16'd3, 16'd9)
        };
        repeat (10)
            script.push_back(item_row(REQ_TICK, 4'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000));

        foreach (script[i])
        begin
            if (script[i].is_reg)
                write_reg(script[i].reg_idx, script[i].reg_val);
            else
                push_word(script[i].word, script[i].typed, script[i].want);
        end

        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            write_reg(CFG_FRAME_TICKS, CFG_DAT_W'(PHASES[ph].frame_ticks));
            write_reg(CFG_CLK_KHZ, CFG_DAT_W'(PHASES[ph].khz));
            write_reg(CFG_SCALE_DIV, CFG_DAT_W'(PHASES[ph].divisor));
            write_reg(CFG_TIMEOUT, CFG_DAT_W'(PHASES[ph].timeout));
            tx_gap_pct   = (PHASES[ph].mode == IDLE_TX) ? 70 :
                           (PHASES[ph].mode == IDLE_BOTH) ? 18 : 0;
            rx_stall_pct = (PHASES[ph].mode == IDLE_RX) ? 70 :
                           (PHASES[ph].mode == IDLE_BOTH) ? 18 : 0;
            half = PHASES[ph].count / 2;
            for (int n = 0; n < PHASES[ph].count; n++)
            begin
                if (n == half)
                begin
                    if (ph % 2 == 0)
                        hold_requests++;
                    else
                    begin
                        // let the block drain completely before going on
                        in_valid <= 1'b0;
                        do @(posedge clk); while (pin_words_due.size() != 0);
                    end
                end
                push_word(random_word(), 1'b0, '0);
            end
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pin_words_due.size() != 0);
        repeat (20) @(posedge clk);

        $display("covered %0d input words, %0d of them position writes, over %0d register writes",
                 words_sent, position_writes, reg_writes);
        $display("%0d result words checked, %0d driven frames", words_checked, driven_frames);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

### four_channel_servo_pulse_gen_core.f
hw/rtl/spg_pkg.sv
hw/rtl/spg_scaler.sv
hw/rtl/spg_datapath.sv
hw/rtl/spg_ctrl.sv
hw/rtl/four_channel_servo_pulse_gen_core.sv
tb/four_channel_servo_pulse_gen_core_tb.sv
